// File: rtl/nlms_pkg.sv
// Package for the NLMS adaptive filter: types, widths and shared constants.
// No dependencies.
package nlms_pkg;

    localparam int TapsDefault     = 256;
    localparam int SampleW         = 16;
    localparam int WeightW         = 32;
    localparam int PowerW          = 48;
    localparam int StepW           = 25;
    localparam int GainW           = 16;
    localparam int AccW            = 58;
    localparam logic [GainW-1:0] GainReset = 16'd2621;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT,
        ST_DIV,
        ST_UPD,
        ST_OUT
    } nlms_state_t;

    // Multiplier request: one signed product per cycle.
    typedef struct packed {
        logic signed [WeightW-1:0] a;
        logic signed [SampleW-1:0] b;
    } mul_req_t;

endpackage

// File: rtl/nlms_div.sv
// Restoring divider, one quotient bit per cycle: gain*2^38 / (2^30 + power).
// Depends on nlms_pkg.
module nlms_div
    import nlms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [GainW-1:0]       gain,
    input  logic [PowerW-1:0]      power,
    output logic                   done,
    output logic [StepW-1:0]       quotient
);

    // Quotient is below 2^24 since gain < 2^16 and divisor >= 2^30.
    localparam int NumW = 54;
    localparam int DivW = PowerW + 1;
    localparam int CntW = 6;

    logic [DivW:0]     rem_reg, rem_next;
    logic [NumW-1:0]   num_reg, num_next;
    logic [DivW-1:0]   den_reg, den_next;
    logic [StepW-1:0]  quo_reg, quo_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DivW:0]     trial;
    logic [DivW:0]     shifted;

    always_comb
    begin
        shifted   = {rem_reg[DivW-1:0], num_reg[NumW-1]};
        trial     = shifted - {1'b0, den_reg};
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            num_next  = {gain, 38'd0};
            den_next  = {1'b0, power} + (DivW'(1) << 30);
            quo_next  = '0;
            cnt_next  = CntW'(NumW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NumW-2:0], 1'b0};
            if (!trial[DivW])
            begin
                rem_next = trial;
                quo_next = {quo_reg[StepW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[StepW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/nlms_mul.sv
// Registered 32x16 signed multiplier used by the filter pass.
// Depends on nlms_pkg.
module nlms_mul
    import nlms_pkg::*;
(
    input  logic                              clk,
    input  mul_req_t                          req,
    output logic signed [WeightW+SampleW-1:0] prod
);

    logic signed [WeightW+SampleW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= req.a * req.b;
    end

    assign prod = prod_reg;

endmodule

// File: rtl/normalized_lms_adaptive_filter.sv
// Normalized LMS adaptive FIR noise canceller, top level.
// Depends on nlms_pkg, nlms_mul, nlms_div.
//
// Usage:
//   Input request: reference_sample and desired_sample with in_valid/in_stall.
//   One output request per input: error_sample with out_valid/out_stall.
//   Config: step_gain written through cfg_valid/cfg_ready while idle.
// Steps per item:
//   filter pass  through the multiplier (one tap per cycle,
//                weight and history memories read one address per cycle),
//   step divide  in the bit-serial divider,
//   update pass  step*error times each delayed sample;
//   in_stall is high from accept until out_valid rises, so a new item is
//   not taken before the last result is in the output register.
// The result sits in an output register; the next item is taken while it
// waits, but finishing that item waits until the register is free.
// Reset: power cleared, step_gain back to 2621, then a clearing pass
// zeroes weights and history while in_stall is held high.
module normalized_lms_adaptive_filter
    import nlms_pkg::*;
#(
    parameter int TAPS = TapsDefault
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [SampleW-1:0] reference_sample,
    input  logic signed [SampleW-1:0] desired_sample,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [SampleW-1:0] error_sample,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [GainW-1:0]          step_gain
);

    localparam int IdxW = $clog2(TAPS);
    localparam int CntW = $clog2(TAPS + 8);
    localparam int ProdW = WeightW + SampleW;
    localparam logic [PowerW-1:0] PowerMax = '1;

    nlms_state_t state_reg, state_next;

    logic [WeightW-1:0]        wmem [TAPS];
    logic [SampleW-1:0]        hmem [TAPS];
    logic                      clr_reg;
    logic [IdxW-1:0]           clr_idx_reg;

    logic [GainW-1:0]          gain_reg;
    logic [PowerW-1:0]         power_reg, power_next;
    logic [IdxW-1:0]           ptr_reg;
    logic signed [SampleW-1:0] x_reg, d_reg, leave_reg;
    logic [CntW-1:0]           cnt_reg, cnt_next;
    logic signed [AccW-1:0]    acc_reg;
    logic signed [SampleW-1:0] err_reg;
    logic signed [SampleW-1:0] out_reg;
    logic                      out_vld_reg;
    logic                      have_item_reg;
    logic signed [StepW+SampleW:0] se_reg;

    // Read pipeline: address issue -> data reg -> product reg.
    logic [IdxW-1:0]           rd_k;
    logic [IdxW-1:0]           hrd_addr;
    logic                      rd_en;
    logic [WeightW-1:0]        wrd_reg;
    logic [SampleW-1:0]        hrd_reg;
    logic [IdxW-1:0]           k1_reg, k2_reg, k3_reg;
    logic                      p1_reg, p2_reg, p3_reg;
    logic signed [WeightW-1:0] w2_reg, w3_reg;
    logic signed [SampleW-1:0] h2_reg;
    logic signed [WeightW-1:0] wq;
    logic signed [SampleW-1:0] hq;

    mul_req_t                  mreq;
    logic signed [ProdW-1:0]   mprod;
    logic signed [ProdW+16:0]  delta_prod;
    logic signed [ProdW+16:0]  delta_rnd;
    logic signed [WeightW+1:0] wsum;
    logic signed [WeightW-1:0] wnew;

    logic                      div_start, div_done;
    logic [StepW-1:0]          step_q;

    logic signed [AccW-1:0]    y_rnd;
    logic signed [SampleW+1:0] e_full;
    logic signed [SampleW-1:0] e_sat;
    logic [2*SampleW-1:0]      sq_in, sq_out;

    nlms_mul u_mul (.clk(clk), .req(mreq), .prod(mprod));

    // Divider starts on the same edge that loads the new power.
    nlms_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .gain(gain_reg), .power(power_next),
        .done(div_done), .quotient(step_q)
    );

    // Tap k reads history slot ptr - k, wrapping at TAPS.
    assign rd_k     = cnt_reg[IdxW-1:0];
    assign hrd_addr = (ptr_reg >= rd_k) ? ptr_reg - rd_k
                                        : IdxW'(TAPS) + ptr_reg - rd_k;
    assign rd_en = ((state_reg == ST_FILT) || (state_reg == ST_UPD))
                   && (cnt_reg < CntW'(TAPS));

    always_ff @(posedge clk)
    begin
        wrd_reg <= wmem[rd_k];
        hrd_reg <= hmem[hrd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg    <= 1'b0;
            p2_reg    <= 1'b0;
            p3_reg    <= 1'b0;
        end
        else
        begin
            p1_reg    <= rd_en;
            p2_reg    <= p1_reg;
            p3_reg    <= p2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        k1_reg <= rd_k;
        k2_reg <= k1_reg;
        k3_reg <= k2_reg;
        w2_reg <= wq;
        w3_reg <= w2_reg;
        h2_reg <= hq;
    end

    assign wq = $signed(wrd_reg);
    assign hq = $signed(hrd_reg);

    // Filter pass multiplies weight*sample; update pass multiplies se*sample
    // (se fits 42 bits, split not needed: se*sample done as 42x16 below).
    always_comb
    begin
        mreq.a = wq;
        mreq.b = hq;
    end

    // Update product: step*err already registered in se_reg (42 bits),
    // times the delayed sample, registered before rounding.
    logic signed [StepW+2*SampleW:0] upd_prod_reg;
    always_ff @(posedge clk)
    begin
        upd_prod_reg <= se_reg * h2_reg;
    end

    assign delta_prod = (ProdW+17)'(upd_prod_reg);
    assign delta_rnd  = (delta_prod + (ProdW+17)'(1 << 25)) >>> 26;
    assign wsum       = (WeightW+2)'(w3_reg) + (WeightW+2)'(delta_rnd);
    always_comb
    begin
        if (wsum > (WeightW+2)'(32'sh7FFF_FFFF))
            wnew = 32'sh7FFF_FFFF;
        else if (wsum < -(WeightW+2)'(34'sh0_8000_0000))
            wnew = 32'sh8000_0000;
        else
            wnew = wsum[WeightW-1:0];
    end

    // A huge filter output drives the error to the opposite rail.
    assign y_rnd  = (acc_reg + AccW'(1 << 27)) >>> 28;
    assign e_full = (SampleW+2)'(d_reg) - (SampleW+2)'(y_rnd);
    always_comb
    begin
        if (y_rnd > AccW'(65536))
            e_sat = 16'sh8000;
        else if (y_rnd < -AccW'(65536))
            e_sat = 16'sh7FFF;
        else if (e_full > (SampleW+2)'(32767))
            e_sat = 16'sh7FFF;
        else if (e_full < -(SampleW+2)'(32768))
            e_sat = 16'sh8000;
        else
            e_sat = e_full[SampleW-1:0];
    end

    assign sq_in  = 32'(x_reg * x_reg);
    assign sq_out = 32'(leave_reg * leave_reg);

    always_comb
    begin
        logic [PowerW:0] t;
        t = (power_reg >= PowerW'(sq_out)) ? {1'b0, power_reg - PowerW'(sq_out)} : '0;
        t = t + (PowerW+1)'(sq_in);
        power_next = t[PowerW] ? PowerMax : t[PowerW-1:0];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (have_item_reg) state_next = ST_FILT;
            ST_FILT: if (cnt_reg == CntW'(TAPS + 2)) state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_UPD;
            ST_UPD:  if (cnt_reg == CntW'(TAPS + 3)) state_next = ST_OUT;
            ST_OUT:  if (!out_vld_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: cnt_next = '0;
            ST_FILT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (state_next == ST_DIV)
                begin
                    div_start = 1'b1;
                    cnt_next  = '0;
                end
            end
            ST_DIV:  cnt_next = '0;
            ST_UPD:  cnt_next = cnt_reg + 1'b1;
            ST_OUT:  cnt_next = '0;
            default: cnt_next = '0;
        endcase
    end

    assign in_stall  = have_item_reg || clr_reg;
    assign cfg_ready = (state_reg == ST_IDLE) && !have_item_reg && !clr_reg;
    assign out_valid = out_vld_reg;
    assign error_sample = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            have_item_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
            gain_reg      <= GainReset;
            power_reg     <= '0;
            ptr_reg       <= '0;
            clr_reg       <= 1'b1;
            clr_idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (clr_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == IdxW'(TAPS - 1))
                    clr_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
                gain_reg <= step_gain;
            if (in_valid && !in_stall)
                have_item_reg <= 1'b1;
            if (out_vld_reg && !out_stall)
                out_vld_reg <= 1'b0;
            if (state_reg == ST_FILT && state_next == ST_DIV)
                power_reg <= power_next;
            if (state_reg == ST_OUT && !out_vld_reg)
            begin
                out_vld_reg   <= 1'b1;
                have_item_reg <= 1'b0;
                ptr_reg       <= (ptr_reg == IdxW'(TAPS - 1)) ? '0 : ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            wmem[clr_idx_reg] <= '0;
            hmem[clr_idx_reg] <= '0;
        end
        if (in_valid && !in_stall)
        begin
            x_reg <= reference_sample;
            d_reg <= desired_sample;
        end
        if (state_reg == ST_IDLE && have_item_reg)
        begin
            leave_reg     <= $signed(hmem[ptr_reg]);
            hmem[ptr_reg] <= x_reg;
            acc_reg       <= '0;
        end
        if (state_reg == ST_FILT && p2_reg)
            acc_reg <= acc_reg + AccW'(mprod);
        if (state_reg == ST_FILT && state_next == ST_DIV)
            err_reg <= e_sat;
        if (div_done)
            se_reg <= $signed({1'b0, step_q}) * err_reg;
        if (state_reg == ST_UPD && p3_reg)
            wmem[k3_reg] <= wnew;
        if (state_reg == ST_OUT && !out_vld_reg)
            out_reg <= err_reg;
    end

endmodule

// File: rtl/nlms_checker.sv
// Port-level checker for the NLMS filter, bound to the top level.
// Depends on nlms_pkg.
module nlms_checker
    import nlms_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [SampleW-1:0] error_sample,
    input logic                      cfg_valid,
    input logic                      cfg_ready
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(error_sample))
        else $error("result changed while stalled");

    // An accepted request makes the block busy next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after request");

    // No config writes while an item is in flight.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !cfg_ready)
        else $error("config ready while busy");

    // A result cannot follow a request in the very next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result too early");

endmodule

bind normalized_lms_adaptive_filter nlms_checker u_nlms_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .error_sample(error_sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
